[rtl/tpq_pkg.sv]
// Shared types and constants for the two-class priority queue.
// Depends on nothing; every other file but tpq_ram imports it.
package tpq_pkg;

    // Fixed field widths
    localparam int AGE_BITS = 7;
    localparam int TAG_BITS = 32;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_PRIORITY_AGE = 1'b0;   // register index in paddr[2]
    localparam logic [AGE_BITS-1:0] PRIORITY_AGE_RESET = 7'd60;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                cmd;
        logic [AGE_BITS-1:0] age;
        logic [TAG_BITS-1:0] tag;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [AGE_BITS-1:0] out_age;
        logic [TAG_BITS-1:0] out_tag;
        logic                out_priority;
    } t_result;

    // One stored entry
    typedef struct packed {
        logic [AGE_BITS-1:0] age;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;     // latch the accepted beat
        logic pop;      // issue the store read, move head, drop count
        logic finish;   // emit insert, full or empty result
        logic emit;     // emit removed entry from store read data
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic is_remove;
        logic avail;    // at least one class holds an entry
    } t_dp_stat;

endpackage

[rtl/tpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tpq_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tpq_ctrl.sv]
// Controller state machine: sequences accept, execute and store read.
// Depends on tpq_pkg.
module tpq_ctrl
    import tpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_remove && i_stat.avail) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_READ;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/tpq_dp.sv]
// Datapath: latched beat, per-class pointers and counts, two entry stores,
// result register. Depends on tpq_pkg and tpq_ram.
module tpq_dp
    import tpq_pkg::*;
#(
    parameter int CLASS_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_in_item            i_item,
    input  logic [AGE_BITS-1:0] i_priority_age,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_valid,
    output t_result             o_result
);

    localparam int AW = $clog2(CLASS_DEPTH);
    localparam int CW = $clog2(CLASS_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(CLASS_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CLASS_DEPTH);

    // Latched beat
    t_in_item r_item;
    logic     r_is_pri;

    // Class bookkeeping
    logic [AW-1:0] r_p_head, r_p_tail, r_n_head, r_n_tail;
    logic [CW-1:0] r_p_count, r_n_count;
    logic          r_pop_pri;

    // Result register
    logic    r_valid;
    t_result r_result;

    // Store ports
    logic    p_we, n_we, p_re, n_re;
    t_entry  wr_entry, p_rdata, n_rdata, rd_entry;
    logic    ins_full;
    t_status fin_status;

    function automatic logic [AW-1:0] f_advance(input logic [AW-1:0] ptr);
        f_advance = (ptr == LAST_PTR) ? '0 : ptr + AW'(1);
    endfunction

    assign ins_full = r_is_pri ? (r_p_count == FULL_CNT) : (r_n_count == FULL_CNT);

    assign o_stat.is_remove = (r_item.cmd == CMD_REMOVE);
    assign o_stat.avail     = (r_p_count != '0) || (r_n_count != '0);

    // Status of a beat that ends without a store read
    assign fin_status = o_stat.is_remove ? ST_EMPTY : (ins_full ? ST_FULL : ST_INSERTED);

    // Store writes and reads
    assign wr_entry = '{age: r_item.age, tag: r_item.tag};
    assign p_we = i_cmd.finish && !o_stat.is_remove && !ins_full && r_is_pri;
    assign n_we = i_cmd.finish && !o_stat.is_remove && !ins_full && !r_is_pri;
    assign p_re = i_cmd.pop && (r_p_count != '0);
    assign n_re = i_cmd.pop && (r_p_count == '0);
    assign rd_entry = r_pop_pri ? p_rdata : n_rdata;

    tpq_ram #(.WIDTH($bits(t_entry)), .DEPTH(CLASS_DEPTH)) u_pri_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_p_tail),
        .i_wdata (wr_entry),
        .i_re    (p_re),
        .i_raddr (r_p_head),
        .o_rdata (p_rdata)
    );

    tpq_ram #(.WIDTH($bits(t_entry)), .DEPTH(CLASS_DEPTH)) u_nrm_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_n_tail),
        .i_wdata (wr_entry),
        .i_re    (n_re),
        .i_raddr (r_n_head),
        .o_rdata (n_rdata)
    );

    // Beat latch; class is decided against the threshold at accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_item;
            r_is_pri <= (i_item.age >= i_priority_age);
        end
        if (i_cmd.pop) begin
            r_pop_pri <= (r_p_count != '0);
        end
    end

    // Pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_head  <= '0;
            r_p_tail  <= '0;
            r_p_count <= '0;
            r_n_head  <= '0;
            r_n_tail  <= '0;
            r_n_count <= '0;
        end else begin
            if (p_we) begin
                r_p_tail  <= f_advance(r_p_tail);
                r_p_count <= r_p_count + CW'(1);
            end
            if (n_we) begin
                r_n_tail  <= f_advance(r_n_tail);
                r_n_count <= r_n_count + CW'(1);
            end
            if (p_re) begin
                r_p_head  <= f_advance(r_p_head);
                r_p_count <= r_p_count - CW'(1);
            end
            if (n_re) begin
                r_n_head  <= f_advance(r_n_head);
                r_n_count <= r_n_count - CW'(1);
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish || i_cmd.emit;
        end
    end

    // Result beat; entry fields stay zero unless an entry is removed
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result <= '{status: fin_status, out_age: '0, out_tag: '0, out_priority: 1'b0};
        end else if (i_cmd.emit) begin
            r_result <= '{status: ST_REMOVED, out_age: rd_entry.age, out_tag: rd_entry.tag,
                          out_priority: r_pop_pri};
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/two_class_priority_queue.sv]
// Two-class priority queue: insert, full and empty results strobe after the
// EXEC state, a removal after the EXEC and READ states; the next beat is
// accepted in the cycle the strobe shows; removals take longer, set by the store's
// registered read. The receiver cannot stall. Reset is synchronous, active low:
// both classes empty, priority_age = 60; store contents are not cleared.
// Depends on tpq_pkg, tpq_ctrl, tpq_dp, tpq_ram.
module two_class_priority_queue
    import tpq_pkg::*;
#(
    parameter int CLASS_DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command channel
    input  logic                     start,
    output logic                     busy,
    input  t_in_item                 i_item,
    output logic                     o_valid,
    output t_result                  o_result,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [AGE_BITS-1:0] r_priority_age;
    logic                cfg_wr;
    t_dp_cmd             dp_cmd;
    t_dp_stat            dp_stat;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PRIORITY_AGE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_priority_age <= PRIORITY_AGE_RESET;
        end else if (cfg_wr) begin
            r_priority_age <= pwdata[AGE_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_PRIORITY_AGE) ?
                    {{(APB_DATA_BITS-AGE_BITS){1'b0}}, r_priority_age} : '0;

    tpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    tpq_dp #(.CLASS_DEPTH(CLASS_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_priority_age (r_priority_age),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_valid        (o_valid),
        .o_result       (o_result)
    );

endmodule

[tb/tb_two_class_priority_queue.sv]
// Testbench for the two-class priority queue: directed and random command beats
// checked against a behavioral model of both classes, across several thresholds.
// Depends on tpq_pkg and two_class_priority_queue.
`timescale 1ns / 1ps

module tb_two_class_priority_queue
    import tpq_pkg::*;
();

    localparam int DEPTH = 16;
    localparam logic [APB_ADDR_BITS-1:0] PRIO_AGE_ADDR = {REG_PRIORITY_AGE, 2'b00};
    localparam int ITEMS_PER_BLOCK = 210;

    // Behavioral model of both classes plus the queue of results still owed
    class tpq_order_tracker;
        t_entry  prio_entries[$];
        t_entry  norm_entries[$];
        t_result owed_results[$];
        logic [AGE_BITS-1:0] prio_age;
        int depth;
        int errors;

        function new(int d);
            depth    = d;
            prio_age = PRIORITY_AGE_RESET;
            errors   = 0;
        endfunction

        function void set_prio_age(logic [AGE_BITS-1:0] v);
            prio_age = v;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Apply one accepted beat to the model and queue its result
        function void accept_beat(t_in_item beat);
            t_result r;
            t_entry  e;
            r = '0;
            e.age = beat.age;
            e.tag = beat.tag;
            if (beat.cmd == CMD_INSERT) begin
                if (beat.age >= prio_age) begin
                    if (prio_entries.size() >= depth) r.status = ST_FULL;
                    else begin
                        prio_entries.push_back(e);
                        r.status = ST_INSERTED;
                    end
                end else begin
                    if (norm_entries.size() >= depth) r.status = ST_FULL;
                    else begin
                        norm_entries.push_back(e);
                        r.status = ST_INSERTED;
                    end
                end
            end else if (prio_entries.size() > 0) begin
                e = prio_entries.pop_front();
                r.status       = ST_REMOVED;
                r.out_age      = e.age;
                r.out_tag      = e.tag;
                r.out_priority = 1'b1;
            end else if (norm_entries.size() > 0) begin
                e = norm_entries.pop_front();
                r.status  = ST_REMOVED;
                r.out_age = e.age;
                r.out_tag = e.tag;
            end else begin
                r.status = ST_EMPTY;
            end
            owed_results.push_back(r);
        endfunction

        // Compare a result beat against the oldest owed result
        function void check_result(t_result got);
            t_result want;
            bit bad;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: expected no result, got status=%0d age=%0d tag=%h prio=%b",
                         $time, got.status, got.out_age, got.out_tag, got.out_priority);
                return;
            end
            want = owed_results.pop_front();
            bad = 1'b0;
            if (got.status !== want.status) bad = 1'b1;
            if (got.out_age !== want.out_age) bad = 1'b1;
            if (got.out_tag !== want.out_tag) bad = 1'b1;
            if (got.out_priority !== want.out_priority) bad = 1'b1;
            if (bad) begin
                errors++;
                $display("%0t: mismatch expected status=%0d age=%0d tag=%h prio=%b,",
                         $time, want.status, want.out_age, want.out_tag,
                         want.out_priority);
                $display("    got status=%0d age=%0d tag=%h prio=%b",
                         got.status, got.out_age, got.out_tag, got.out_priority);
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    t_in_item                 i_item = '0;
    logic                     o_valid;
    t_result                  o_result;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    tpq_order_tracker tracker = new(DEPTH);
    int idle_pct = 0;

    two_class_priority_queue #(.CLASS_DEPTH(DEPTH)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result monitor: every strobed beat is checked
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            tracker.check_result(o_result);
        end
    end

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Hold start high until the beat is taken, then note it in the model
    task automatic send_beat(input t_in_item beat);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        tracker.accept_beat(beat);
        if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 4));
    endtask

    // Idle the command side and let every owed result come back
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Read priority_age back and compare its low bits with the model
    task automatic read_back_prio_age();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PRIO_AGE_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[AGE_BITS-1:0] !== tracker.prio_age) begin
            tracker.errors++;
            $display("%0t: priority_age readback expected %0d, got %0d",
                     $time, tracker.prio_age, prdata[AGE_BITS-1:0]);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_prio_age(input logic [APB_DATA_BITS-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PRIO_AGE_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        tracker.set_prio_age(data[AGE_BITS-1:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_back_prio_age();
    endtask

    function automatic t_in_item make_beat(input t_cmd cmd, input logic [AGE_BITS-1:0] age,
                                           input logic [TAG_BITS-1:0] tag);
        t_in_item b;
        b.cmd = cmd;
        b.age = age;
        b.tag = tag;
        return b;
    endfunction

    // Random beat: ages cluster at the threshold and the extremes
    function automatic t_in_item random_beat(input int insert_pct);
        t_in_item b;
        logic [AGE_BITS-1:0] thr;
        thr = tracker.prio_age;
        b.cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        case ($urandom_range(9))
            0, 1, 2: b.age = thr + AGE_BITS'($urandom_range(2)) - AGE_BITS'(1);
            3:       b.age = $urandom_range(1) ? '1 : '0;
            default: b.age = AGE_BITS'($urandom);
        endcase
        if ($urandom_range(9) == 0) b.tag = $urandom_range(1) ? '1 : '0;
        else b.tag = TAG_BITS'($urandom);
        return b;
    endfunction

    // Runs of fill-heavy, drain-heavy and mixed traffic
    task automatic random_block(input int count);
        int left;
        int run_len;
        int ins_pct;
        left = count;
        while (left > 0) begin
            case ($urandom_range(2))
                0:       ins_pct = 85;
                1:       ins_pct = 15;
                default: ins_pct = 50;
            endcase
            run_len = $urandom_range(10, 40);
            if (run_len > left) run_len = left;
            repeat (run_len) send_beat(random_beat(ins_pct));
            left -= run_len;
        end
    endtask

    initial begin
        logic [APB_DATA_BITS-1:0] plan[9];
        int blk;
        plan = '{32'd0, 32'd127, {$urandom} & ~32'h7f | 32'($urandom_range(127)),
                 32'd1, 32'd126, 32'($urandom_range(127)),
                 32'd60, 32'($urandom_range(127)), 32'd127};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset value of the register
        read_back_prio_age();

        // Directed: empty remove, both classes at the threshold edge, strict order
        send_beat(make_beat(CMD_REMOVE, '1, '1));
        send_beat(make_beat(CMD_INSERT, 7'd59, '0));
        send_beat(make_beat(CMD_INSERT, 7'd60, '1));
        send_beat(make_beat(CMD_INSERT, 7'd127, 32'h1234_5678));
        send_beat(make_beat(CMD_INSERT, 7'd0, 32'ha5a5_a5a5));
        send_beat(make_beat(CMD_INSERT, 7'd61, 32'h5a5a_5a5a));
        repeat (5) send_beat(make_beat(CMD_REMOVE, '0, '0));
        send_beat(make_beat(CMD_REMOVE, 7'h55, 32'hdead_beef));
        send_beat(make_beat(CMD_INSERT, 7'd60, 32'h0000_0001));
        send_beat(make_beat(CMD_REMOVE, '0, '0));
        drain();

        // Random traffic in three idling regimes, threshold changed between blocks
        for (blk = 0; blk < 9; blk++) begin
            idle_pct = (blk < 3) ? 20 : (blk < 6) ? 47 : 0;
            write_prio_age(plan[blk]);
            random_block(ITEMS_PER_BLOCK);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("PASS two_class_priority_queue");
        end else begin
            $display("FAIL two_class_priority_queue");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("FAIL two_class_priority_queue");
        $finish;
    end

endmodule

[two_class_priority_queue.f]
rtl/tpq_pkg.sv
rtl/tpq_ram.sv
rtl/tpq_ctrl.sv
rtl/tpq_dp.sv
rtl/two_class_priority_queue.sv
tb/tb_two_class_priority_queue.sv
